>>> hw/rtl/sdec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdec_pkg
// shared types and constants for the signed integer to decimal text unit
// ----------------------------------------------------------------------------
package sdec_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned BITCNT_W = 5;

    localparam logic [CHAR_W-1:0]   CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 7'd48;
    localparam logic [BITCNT_W-1:0] LAST_BIT   = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_SIGN,
        ST_DIGIT
    } sdec_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic size;
        logic emit_sign;
        logic emit_digit;
    } sdec_cmd_t;

    typedef struct packed {
        logic shift_last;
        logic neg;
        logic idx_zero;
        logic out_free;
    } sdec_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/sdec_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdec_datapath
// magnitude, shift-add-3 bcd conversion, digit count and output word register
// ----------------------------------------------------------------------------
module sdec_datapath
    import sdec_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic signed [31:0]  value,
    input  wire sdec_cmd_t           cmd,
    output sdec_status_t             status,
    output logic [CHAR_W-1:0]        char_code,
    output logic [LEN_W-1:0]         text_length,
    output logic                     last_char,
    output logic                     out_valid,
    input  wire logic                out_stall
);

    logic [VALUE_W-1:0]  mag_reg,  mag_next;
    logic [BCD_W-1:0]    bcd_reg,  bcd_next;
    logic                neg_reg,  neg_next;
    logic [BITCNT_W-1:0] cnt_reg,  cnt_next;
    logic [LEN_W-1:0]    len_reg,  len_next;
    logic [IDX_W-1:0]    idx_reg,  idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg,  char_next;
    logic [LEN_W-1:0]    olen_reg,  olen_next;
    logic                last_reg,  last_next;

    logic [BCD_W-1:0]    bcd_adj;
    logic [IDX_W-1:0]    nd;
    logic [3:0]          sel_digit;
    logic [VALUE_W-1:0]  raw;

    assign raw = $unsigned(value);

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // number of significant digits, at least one
    always_comb
    begin
        nd = IDX_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                nd = IDX_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        sel_digit = 4'd0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (idx_reg == IDX_W'(i))
            begin
                sel_digit = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            neg_next = raw[VALUE_W-1];
            mag_next = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
            bcd_next = '0;
            cnt_next = '0;
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + BITCNT_W'(1);
        end
        else if (cmd.size)
        begin
            len_next = nd + {{(LEN_W-1){1'b0}}, neg_reg};
            idx_next = nd - IDX_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        char_next      = char_reg;
        olen_next      = olen_reg;
        last_next      = last_reg;
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_MINUS;
            olen_next      = len_reg;
            last_next      = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_ZERO + {3'b000, sel_digit};
            olen_next      = len_reg;
            last_next      = (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        olen_reg <= olen_next;
        last_reg <= last_next;
    end

    assign status.shift_last = (cnt_reg == LAST_BIT);
    assign status.neg        = neg_reg;
    assign status.idx_zero   = (idx_reg == '0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign char_code   = char_reg;
    assign text_length = olen_reg;
    assign last_char   = last_reg;
    assign out_valid   = out_valid_reg;

endmodule
`default_nettype wire

>>> hw/rtl/sdec_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdec_ctrl
// sequencer: load, 32 conversion shifts, sizing, then one word per character
// ----------------------------------------------------------------------------
module sdec_ctrl
    import sdec_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire sdec_status_t status,
    output sdec_cmd_t         cmd
);

    sdec_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.shift_last)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free && status.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
            end
            ST_SIZE:
            begin
                cmd.size = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// signed 32-bit integer to decimal ascii text, one character per word
// ----------------------------------------------------------------------------
// Each accepted input word is a two's complement 32-bit value; the unit
// emits its decimal text most significant digit first, preceded by '-' for
// negative values, no leading zeros, zero as a single '0', and the most
// negative value as "-2147483648". Every output word carries the character,
// the total text length (1 to 11) and a last-character flag. Each value is
// loaded in the idle state in which it is accepted, converted by shift-add-3
// steps (one magnitude bit per cycle through the bcd register), sized, and
// then sent one character per output word as the output side takes them.
// Input is taken only in idle; the output word sits in a register, so a new
// value can be accepted while the last character still waits to be taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sdec_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] value,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              char_code,
    output logic [3:0]              text_length,
    output logic                    last_char
);

    // commands from the sequencer, status back from the datapath
    sdec_cmd_t    cmd;
    sdec_status_t status;

    // controller: walks load, conversion, sizing, sign and digit emission
    sdec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: magnitude and bcd registers, digit count, output word
    sdec_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .char_code   (char_code),
        .text_length (text_length),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule
`default_nettype wire

>>> bench/signed_int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// self-checking bench for the signed integer to decimal text unit
// ----------------------------------------------------------------------------
// A queue of input words is filled at time zero: a directed set first (zero,
// one-digit values, powers of ten and their neighbors, the largest value,
// the most negative value, alternating bit patterns), then random words.
// Four in ten random words target a chosen digit count with a random sign. A
// clocked driver offers the words in bursts with random gaps. The receiver
// stalls on a pattern of its own and holds off once for a long stretch, so
// the unit fills up and stalls its input. For every accepted input word the
// expected characters are computed and queued; a clocked monitor checks each
// output word against the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb
    import sdec_pkg::*;
;

    localparam int          CLK_PERIOD     = 8;
    localparam int          RANDOM_WORDS   = 400;
    localparam int          HOLD_START     = 3000;     // receiver cycle of the long hold-off
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 60;       // longer than one full conversion
    localparam longint      TIMEOUT_CYCLES = 1000000;
    localparam logic [31:0] MOST_NEGATIVE  = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE  = 32'h7FFF_FFFF;

    // kinds of random input word
    typedef enum int {
        VAL_FULL,       // any 32-bit pattern
        VAL_DIGITS,     // chosen digit count, random sign
        VAL_EDGE,       // a power of ten and its neighbors
        VAL_TINY        // small values around zero
    } value_kind_t;

    // receiver stall patterns
    typedef enum int {
        RX_NONE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } stall_mode_t;

    // one expected output character
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic              last;
    } text_char_t;

    // every input starts at a known value
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [31:0]      value     = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [6:0]              char_code;
    logic [3:0]              text_length;
    logic                    last_char;

    logic [VALUE_W-1:0]      word_queue[$];      // input words not yet offered
    text_char_t              text_chars_q[$];    // characters still to come
    int unsigned             fail_count = 0;

    // sender burst state
    int unsigned             burst_left = 0;
    int unsigned             gap_left   = 0;

    // receiver pattern state
    int unsigned             rx_cycle   = 0;
    int unsigned             hold_left  = 0;
    int unsigned             seg_left   = 0;
    stall_mode_t             rx_mode    = RX_NONE;

    signed_int_to_decimal_ascii_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .text_length (text_length),
        .last_char   (last_char)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // decimal text of one word, appended to the expected characters
    // ------------------------------------------------------------------------
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_buf [DIGITS];
        int unsigned        ndig;
        logic               neg;
        logic [LEN_W-1:0]   total;
        text_char_t         ch;

        neg = word[VALUE_W-1];
        // two's complement magnitude, so the most negative value stays 2^31
        mag  = neg ? (~word + 1'b1) : word;
        ndig = 0;
        do
        begin
            digit_buf[ndig] = 4'(mag % 10);
            mag             = mag / 10;
            ndig++;
        end
        while (mag != 0 && ndig < DIGITS);

        total = LEN_W'(ndig + (neg ? 1 : 0));
        if (neg)
        begin
            ch.code   = CHAR_MINUS;
            ch.length = total;
            ch.last   = 1'b0;
            text_chars_q.push_back(ch);
        end
        // most significant digit first
        for (int i = ndig; i > 0; i--)
        begin
            ch.code   = CHAR_ZERO + CHAR_W'(digit_buf[i-1]);
            ch.length = total;
            ch.last   = (i == 1);
            text_chars_q.push_back(ch);
        end
    endfunction

    function automatic longint ten_pow(input int unsigned n);
        longint p;

        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // random input word, weighted toward well-spread digit counts
    // ------------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] random_word();
        value_kind_t        kind;
        int unsigned        n;
        int unsigned        pick;
        logic               neg;
        longint             lo;
        longint             hi;
        logic [VALUE_W-1:0] word;

        pick = $urandom_range(0, 9);
        if (pick < 3)
            kind = VAL_FULL;
        else if (pick < 7)
            kind = VAL_DIGITS;
        else if (pick < 9)
            kind = VAL_EDGE;
        else
            kind = VAL_TINY;

        neg = 1'($urandom_range(0, 1));
        case (kind)
            VAL_FULL:
            begin
                word = $urandom;
            end
            VAL_DIGITS:
            begin
                n  = $urandom_range(1, DIGITS);
                lo = (n == 1) ? 0 : ten_pow(n - 1);
                hi = ten_pow(n) - 1;
                // negative side reaches one further than the positive side
                if (neg && hi > 64'd2147483648)
                    hi = 64'd2147483648;
                else if (!neg && hi > 64'd2147483647)
                    hi = 64'd2147483647;
                word = $urandom_range(32'(hi), 32'(lo));
                if (neg)
                    word = ~word + 1'b1;
            end
            VAL_EDGE:
            begin
                n    = $urandom_range(1, DIGITS - 1);
                word = 32'(ten_pow(n) + $urandom_range(0, 2) - 1);
                if (neg)
                    word = ~word + 1'b1;
            end
            default:
            begin
                word = 32'($signed($urandom_range(0, 40)) - 20);
            end
        endcase
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers queued words in bursts, holds a word while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            value      <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_decimal_text(value);

            // a stalled word stays on the port unchanged
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    value    <= word_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        // end of burst: pick the next burst and the gap before it
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern in segments, plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
            seg_left  = 0;
            rx_mode   = RX_NONE;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;

            if (hold_left != 0)
            begin
                // sender keeps offering, so the unit backs up into its input
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode  = stall_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                end
                else
                    seg_left--;

                case (rx_mode)
                    RX_NONE:   out_stall <= 1'b0;
                    RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    default:   out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each accepted output word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_text
        text_char_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (text_chars_q.size() == 0)
            begin
                $error("unexpected word: char_code %0d text_length %0d last_char %0d",
                       char_code, text_length, last_char);
                fail_count++;
            end
            else
            begin
                want = text_chars_q.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, actual %0d", want.code, char_code);
                    fail_count++;
                end
                if (text_length !== want.length)
                begin
                    $error("text_length: expected %0d, actual %0d", want.length, text_length);
                    fail_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0d, actual %0d", want.last, last_char);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // directed words: zero, single digits, power-of-ten boundaries,
        // extremes of the range and alternating bit patterns
        word_queue.push_back(32'd0);
        word_queue.push_back(32'd1);
        word_queue.push_back(-32'sd1);
        word_queue.push_back(32'd7);
        word_queue.push_back(-32'sd5);
        word_queue.push_back(32'd9);
        word_queue.push_back(-32'sd9);
        word_queue.push_back(32'd10);
        word_queue.push_back(-32'sd10);
        word_queue.push_back(32'd99);
        word_queue.push_back(32'd100);
        word_queue.push_back(-32'sd100);
        word_queue.push_back(32'd12345);
        word_queue.push_back(32'd123456789);
        word_queue.push_back(-32'sd987654321);
        word_queue.push_back(32'd999999999);
        word_queue.push_back(32'd1000000000);
        word_queue.push_back(-32'sd1000000000);
        word_queue.push_back(MOST_POSITIVE);
        word_queue.push_back(MOST_POSITIVE + 1'b1 + 1'b1);     // -2147483647
        word_queue.push_back(MOST_NEGATIVE);
        word_queue.push_back(32'hAAAA_AAAA);
        word_queue.push_back(32'h5555_5555);

        for (int i = 0; i < RANDOM_WORDS; i++)
            word_queue.push_back(random_word());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // all words taken, then all characters seen, then a quiet tail
        while (word_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (text_chars_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && text_chars_q.size() == 0)
            $display("signed_int_to_decimal_ascii_unit_tb OK");
        else
            $display("signed_int_to_decimal_ascii_unit_tb NOT OK");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("signed_int_to_decimal_ascii_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sdec_pkg.sv
hw/rtl/sdec_datapath.sv
hw/rtl/sdec_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
bench/signed_int_to_decimal_ascii_unit_tb.sv
